@@ rtl/tmcw_pkg.sv @@
// Shared constants and types for the text-mode console writer.
package tmcw_pkg;

    localparam int COLS       = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CELL_W     = 16;
    localparam int MUL_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int COLOR_W    = 4;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_MOVE  = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 2'd1;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LAST  = 8'h7F;

    localparam logic [7:0] RESET_ATTR = 8'h0F;
    localparam logic [COLOR_W-1:0] RESET_FG = 4'hF;
    localparam logic [COLOR_W-1:0] RESET_BG = 4'h0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_FILL
    } state_t;

endpackage

@@ rtl/tmcw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tmcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/text_mode_console_writer.sv @@
// Top level of the text-mode console writer: cursor control and cell memory sequencer.
//
// Channel   Direction  Handshake            Payload
// in        request    in_valid / in_stall  operation, char_code, pos_col, pos_row
// out       result     out_valid/out_stall  read_char, read_attr, cursor_col, cursor_row
// cfg       write      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Put character and move cursor answer in the cycle after they are accepted; read
// cell passes through the READ state, since the cell memory read data is registered.
// Clear screen sweeps the cell memory, one cell per cycle; a scroll copies
// CELL_COUNT - COLS cells and then blanks COLS cells on the one write port.
// After reset a clearing pass over all CELL_COUNT cells runs before the first request.
// A stalled result holds the next request off only while it is not taken.
module text_mode_console_writer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         operation,
    input  logic [7:0]                         char_code,
    input  logic [7:0]                         pos_col,
    input  logic [7:0]                         pos_row,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [7:0]                         read_char,
    output logic [7:0]                         read_attr,
    output logic [7:0]                         cursor_col,
    output logic [7:0]                         cursor_row,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tmcw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tmcw_pkg::COLOR_W-1:0]       cfg_data
);

    localparam int AW = tmcw_pkg::ADDR_W;
    localparam logic [AW-1:0] FILL_LAST = AW'(tmcw_pkg::CELL_COUNT - 1);
    localparam logic [AW-1:0] COPY_LAST = AW'(tmcw_pkg::CELL_COUNT - tmcw_pkg::COLS - 1);
    localparam logic [AW-1:0] BLANK_FIRST = AW'(tmcw_pkg::CELL_COUNT - tmcw_pkg::COLS);
    localparam logic [AW-1:0] ROW_STEP = AW'(tmcw_pkg::COLS);
    localparam logic [8:0] COLS9 = 9'(tmcw_pkg::COLS);
    localparam logic [8:0] ROWS9 = 9'(tmcw_pkg::ROWS);

    tmcw_pkg::state_t state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [7:0] fill_attr_reg, fill_attr_next;
    logic [tmcw_pkg::COLOR_W-1:0] fg_reg, bg_reg;
    logic [7:0] col_reg, col_next, row_reg, row_next;
    logic out_valid_reg, out_valid_next;
    logic [7:0] rchar_reg, rchar_next, rattr_reg, rattr_next;
    logic rd_ok_reg, rd_ok_next;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [tmcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

    logic in_acc, out_take;
    logic [7:0] attr;
    logic [AW-1:0] cur_addr, pos_addr;
    logic [tmcw_pkg::MUL_W-1:0] cur_lin, pos_lin;
    logic [8:0] put_col, put_row, mv_col, mv_row;
    logic put_we, put_scroll, pos_ok;

    tmcw_ram #(
        .WIDTH(tmcw_pkg::CELL_W),
        .DEPTH(tmcw_pkg::CELL_COUNT)
    ) u_cells (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign attr      = {bg_reg, fg_reg};
    assign out_take  = out_valid_reg && !out_stall;
    assign in_stall  = !((state_reg == tmcw_pkg::ST_IDLE) && (!out_valid_reg || !out_stall));
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign out_valid  = out_valid_reg;
    assign read_char  = rchar_reg;
    assign read_attr  = rattr_reg;
    assign cursor_col = col_reg;
    assign cursor_row = row_reg;

    assign cur_lin  = tmcw_pkg::MUL_W'(row_reg) * tmcw_pkg::MUL_W'(tmcw_pkg::COLS)
                    + tmcw_pkg::MUL_W'(col_reg);
    assign pos_lin  = tmcw_pkg::MUL_W'(pos_row) * tmcw_pkg::MUL_W'(tmcw_pkg::COLS)
                    + tmcw_pkg::MUL_W'(pos_col);
    assign cur_addr = cur_lin[AW-1:0];
    assign pos_addr = pos_lin[AW-1:0];
    assign pos_ok   = ({1'b0, pos_col} < COLS9) && ({1'b0, pos_row} < ROWS9);

    // Cursor update for put character, including wrap and scroll.
    always_comb
    begin
        put_col = {1'b0, col_reg};
        put_row = {1'b0, row_reg};
        put_we  = 1'b0;
        if (char_code == tmcw_pkg::CH_LF)
        begin
            put_col = 9'd0;
            put_row = put_row + 9'd1;
        end
        else if (char_code == tmcw_pkg::CH_CR)
        begin
            put_col = 9'd0;
        end
        else if (char_code == tmcw_pkg::CH_TAB)
        begin
            put_col = (put_col + 9'd4) & ~9'd3;
        end
        else if (char_code inside {[tmcw_pkg::CH_SPACE:tmcw_pkg::CH_LAST]})
        begin
            put_we  = 1'b1;
            put_col = put_col + 9'd1;
        end
        if (put_col >= COLS9)
        begin
            put_col = 9'd0;
            put_row = put_row + 9'd1;
        end
        put_scroll = (put_row >= ROWS9);
        if (put_scroll)
        begin
            put_col = 9'd0;
            put_row = ROWS9 - 9'd1;
        end
    end

    // Cursor update for move cursor.
    always_comb
    begin
        mv_col = {1'b0, pos_col};
        mv_row = {1'b0, pos_row};
        if (mv_col >= COLS9)
        begin
            mv_col = 9'd0;
            mv_row = mv_row + 9'd1;
        end
        if (mv_row >= ROWS9)
        begin
            mv_row = 9'd0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        fill_attr_next = fill_attr_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg && !out_take;
        rchar_next     = rchar_reg;
        rattr_next     = rattr_reg;
        rd_ok_next     = rd_ok_reg;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg;
        ram_wdata      = {fill_attr_reg, tmcw_pkg::CH_SPACE};
        ram_raddr      = '0;
        case (state_reg)
            tmcw_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    out_valid_next = 1'b1;
                    rchar_next     = 8'd0;
                    rattr_next     = 8'd0;
                    case (operation)
                        tmcw_pkg::OP_PUT:
                        begin
                            ram_we    = put_we;
                            ram_waddr = cur_addr;
                            ram_wdata = {attr, char_code};
                            col_next  = put_col[7:0];
                            row_next  = put_row[7:0];
                            if (put_scroll)
                            begin
                                // Prime the copy with the first cell of row one.
                                ram_raddr      = ROW_STEP;
                                fill_attr_next = attr;
                                cnt_next       = '0;
                                state_next     = tmcw_pkg::ST_COPY;
                            end
                        end
                        tmcw_pkg::OP_CLEAR:
                        begin
                            col_next       = 8'd0;
                            row_next       = 8'd0;
                            fill_attr_next = attr;
                            cnt_next       = '0;
                            state_next     = tmcw_pkg::ST_FILL;
                        end
                        tmcw_pkg::OP_MOVE:
                        begin
                            col_next = mv_col[7:0];
                            row_next = mv_row[7:0];
                        end
                        default:
                        begin
                            out_valid_next = 1'b0;
                            ram_raddr      = pos_addr;
                            rd_ok_next     = pos_ok;
                            state_next     = tmcw_pkg::ST_READ;
                        end
                    endcase
                end
            end
            tmcw_pkg::ST_READ:
            begin
                out_valid_next = 1'b1;
                rchar_next     = rd_ok_reg ? ram_rdata[7:0] : 8'd0;
                rattr_next     = rd_ok_reg ? ram_rdata[15:8] : 8'd0;
                state_next     = tmcw_pkg::ST_IDLE;
            end
            tmcw_pkg::ST_COPY:
            begin
                // The read data holds the cell one row below the write address.
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                if (cnt_reg == COPY_LAST)
                begin
                    cnt_next   = BLANK_FIRST;
                    state_next = tmcw_pkg::ST_FILL;
                end
                else
                begin
                    cnt_next  = cnt_reg + AW'(1);
                    ram_raddr = cnt_reg + ROW_STEP + AW'(1);
                end
            end
            tmcw_pkg::ST_FILL:
            begin
                ram_we = 1'b1;
                if (cnt_reg == FILL_LAST)
                begin
                    cnt_next   = '0;
                    state_next = tmcw_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = tmcw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tmcw_pkg::ST_FILL;
            cnt_reg       <= '0;
            fill_attr_reg <= tmcw_pkg::RESET_ATTR;
            col_reg       <= 8'd0;
            row_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fill_attr_reg <= fill_attr_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            rd_ok_reg     <= rd_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rchar_reg <= rchar_next;
        rattr_reg <= rattr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= tmcw_pkg::RESET_FG;
            bg_reg <= tmcw_pkg::RESET_BG;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tmcw_pkg::CFG_FG: fg_reg <= cfg_data;
                tmcw_pkg::CFG_BG: bg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/tmcw_checker.sv @@
// Port-level checks for the text-mode console writer, bound to the top level.
module tmcw_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] operation,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] read_char,
    input logic [7:0] read_attr,
    input logic [7:0] cursor_col,
    input logic [7:0] cursor_row
);

    // A result held by the receiver keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_char) && $stable(read_attr)
        && $stable(cursor_col) && $stable(cursor_row))
        else $error("stalled result changed");

    // Every request other than a read answers in the next cycle with zero cell data.
    a_non_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation != tmcw_pkg::OP_READ
        |=> out_valid && read_char == 8'd0 && read_attr == 8'd0)
        else $error("non-read result missing or has cell data");

    // Clear homes the cursor and holds off requests while the grid is swept.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation == tmcw_pkg::OP_CLEAR
        |=> cursor_col == 8'd0 && cursor_row == 8'd0 && in_stall)
        else $error("clear did not home the cursor or start the sweep");

    // The cursor reported with a valid result lies on the grid.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(cursor_col) < tmcw_pkg::COLS && 32'(cursor_row) < tmcw_pkg::ROWS)
        else $error("cursor off the grid");

endmodule

bind text_mode_console_writer tmcw_checker u_tmcw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_char (read_char),
    .read_attr (read_attr),
    .cursor_col(cursor_col),
    .cursor_row(cursor_row)
);
